// ===== design/stq_pkg.sv =====
// Shared types, widths and result codes of the sorted timer queue.
package stq_pkg;

  localparam int unsigned MAX_SLEEPERS_DEF = 16;
  localparam int unsigned MAX_RESULTS      = 16;

  localparam int unsigned TIME_W  = 63;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned DUR_W   = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned ENTRY_W = TIME_W + ID_W;
  localparam int unsigned NCNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [KIND_W-1:0] KIND_WOKEN    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] due;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] wake;
    logic [TIME_W-1:0] now;
    logic              last;
  } result_t;

endpackage

// ===== design/stq_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module stq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/stq_ctrl.sv =====
// Sequencer of the timer queue: tick count, ring pointers and table walks.
module stq_ctrl
  import stq_pkg::*;
#(
  parameter int unsigned MAX_SLEEPERS = MAX_SLEEPERS_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_SLEEPERS),
  localparam int unsigned CNT_W = $clog2(MAX_SLEEPERS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [ID_W-1:0]    id_i,
  input  logic [DUR_W-1:0]   dur_i,
  input  logic               out_free_i,
  output result_t            res_o,
  output logic               we_o,
  output logic [IDX_W-1:0]   waddr_o,
  output logic [ENTRY_W-1:0] wdata_o,
  output logic               re_o,
  output logic [IDX_W-1:0]   raddr_o,
  input  logic [ENTRY_W-1:0] rdata_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TCHK  = 3'd1;
  localparam logic [2:0] ST_TLAST = 3'd2;
  localparam logic [2:0] ST_ICHK  = 3'd3;
  localparam logic [2:0] ST_IPUT  = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [TIME_W-1:0] count_q, count_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  wptr_q, wptr_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [NCNT_W-1:0] n_q, n_d;
  entry_t            cur_q, cur_d;
  logic [TIME_W-1:0] due_q, due_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [KIND_W-1:0] kind_q, kind_d;

  entry_t            rd;
  entry_t            new_entry;
  logic [TIME_W:0]   wake_sum;
  logic [TIME_W-1:0] wake_sat;
  logic [CNT_W:0]    tail_sum;
  logic [IDX_W-1:0]  tail_idx;
  logic              rd_due;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
    return (x == IDX_W'(MAX_SLEEPERS - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] x);
    return (x == '0) ? IDX_W'(MAX_SLEEPERS - 1) : x - 1'b1;
  endfunction

  assign rd        = entry_t'(rdata_i);
  assign new_entry = '{due: due_q, id: id_q};
  assign rd_due    = (rd.due <= count_q);

  // The wake time saturates at the top of the 63-bit range.
  assign wake_sum = {1'b0, count_q} + (TIME_W + 1)'(dur_i);
  assign wake_sat = wake_sum[TIME_W] ? '1 : wake_sum[TIME_W-1:0];

  // The table is a ring: entries run from head for occ entries.
  assign tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(occ_q);
  assign tail_idx = (tail_sum >= (CNT_W + 1)'(MAX_SLEEPERS)) ?
                    IDX_W'(tail_sum - (CNT_W + 1)'(MAX_SLEEPERS)) : IDX_W'(tail_sum);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    occ_d      = occ_q;
    head_d     = head_q;
    wptr_d     = wptr_q;
    left_d     = left_q;
    n_d        = n_q;
    cur_d      = cur_q;
    due_d      = due_q;
    id_d       = id_q;
    kind_d     = kind_q;
    in_ready_o = 1'b0;
    res_o      = '0;
    we_o       = 1'b0;
    waddr_o    = wptr_q;
    wdata_o    = ENTRY_W'(new_entry);
    re_o       = 1'b0;
    raddr_o    = head_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i) begin
            due_d = wake_sat;
            id_d  = id_i;
            if (occ_q == CNT_W'(MAX_SLEEPERS)) begin
              kind_d  = KIND_REJECTED;
              state_d = ST_RESP;
            end else begin
              wptr_d = tail_idx;
              left_d = occ_q;
              if (occ_q == '0) begin
                state_d = ST_IPUT;
              end else begin
                re_o    = 1'b1;
                raddr_o = idx_dec(tail_idx);
                state_d = ST_ICHK;
              end
            end
          end else begin
            count_d = count_q + 1'b1;
            n_d     = '0;
            if (occ_q != '0) begin
              re_o    = 1'b1;
              raddr_o = head_q;
              state_d = ST_TCHK;
            end
          end
        end
      end

      // The head entry is on the read port. The previous due entry is sent
      // once we know whether this one follows it.
      ST_TCHK: begin
        if ((n_q != '0) && out_free_i) begin
          res_o = '{valid: 1'b1, kind: KIND_WOKEN, id: cur_q.id, wake: cur_q.due,
                    now: count_q, last: !rd_due};
        end
        if ((n_q == '0) || out_free_i) begin
          if (rd_due) begin
            cur_d  = rd;
            head_d = idx_inc(head_q);
            occ_d  = occ_q - 1'b1;
            n_d    = n_q + 1'b1;
            if ((occ_q > CNT_W'(1)) && (n_q < NCNT_W'(MAX_RESULTS - 1))) begin
              re_o    = 1'b1;
              raddr_o = idx_inc(head_q);
            end else begin
              state_d = ST_TLAST;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_TLAST: begin
        if (out_free_i) begin
          res_o = '{valid: 1'b1, kind: KIND_WOKEN, id: cur_q.id, wake: cur_q.due,
                    now: count_q, last: 1'b1};
          state_d = ST_IDLE;
        end
      end

      // Walk back from the tail, moving later entries up by one slot.
      ST_ICHK: begin
        if (rd.due > due_q) begin
          we_o    = 1'b1;
          waddr_o = wptr_q;
          wdata_o = rdata_i;
          wptr_d  = idx_dec(wptr_q);
          left_d  = left_q - 1'b1;
          if (left_q > CNT_W'(1)) begin
            re_o    = 1'b1;
            raddr_o = idx_dec(idx_dec(wptr_q));
          end else begin
            state_d = ST_IPUT;
          end
        end else begin
          state_d = ST_IPUT;
        end
      end

      ST_IPUT: begin
        we_o    = 1'b1;
        waddr_o = wptr_q;
        occ_d   = occ_q + 1'b1;
        kind_d  = KIND_ACCEPTED;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (out_free_i) begin
          res_o = '{valid: 1'b1, kind: kind_q, id: id_q, wake: due_q,
                    now: count_q, last: 1'b1};
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      occ_q   <= '0;
      head_q  <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      occ_q   <= occ_d;
      head_q  <= head_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wptr_q <= wptr_d;
    left_q <= left_d;
    cur_q  <= cur_d;
    due_q  <= due_d;
    id_q   <= id_d;
    kind_q <= kind_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(MAX_SLEEPERS))
    else $error("occupancy exceeds the table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NCNT_W'(MAX_RESULTS))
    else $error("a tick released more entries than allowed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> out_free_i)
    else $error("result issued into an occupied output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind == KIND_WOKEN)) |-> (res_o.wake <= count_q))
    else $error("woken entry was not yet due");

endmodule

// ===== design/stq_out.sv =====
// Output register of the timer queue, holding one result beat until it is taken.
module stq_out
  import stq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  result_t res_i,
  output logic    free_o,
  output result_t res_o,
  input  logic    ready_i
);

  logic    valid_q;
  result_t data_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.valid) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      data_q <= res_i;
    end
  end

  always_comb begin
    res_o       = data_q;
    res_o.valid = valid_q;
  end

endmodule

// ===== design/sleep_wakeup_timer_queue.sv =====
// Sorted timer queue: keeps a 63-bit tick count and a table of sleeping threads, ordered
// by wake time with equal times served in arrival order, held as a ring in one RAM with a
// registered read port. A tick beat releases the due entries from the head of the table
// (at most 16 released per tick). A sleep beat is rejected on a full table and otherwise
// walks back from the tail, reading each queued entry due later than the new one, and the
// entry that stops the walk when there is one. The table walk reads one RAM entry per
// cycle while it does not wait for the output register, and a tick's walk waits whenever a
// result waits for the output register to drain. Results leave through an output register,
// so a new beat is taken while the last result still waits. The table needs no clearing
// after reset.
module sleep_wakeup_timer_queue
  import stq_pkg::*;
#(
  parameter int unsigned MAX_SLEEPERS = MAX_SLEEPERS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [39:0]  s_axis_tdata_i,   // thread_id[7:0], sleep_ticks[39:8]
  input  logic         s_axis_tuser_i,   // op
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [135:0] m_axis_tdata_o,   // woken_id[7:0], wake_time[70:8], now_ticks[133:71]
  output logic [1:0]   m_axis_tuser_o,   // kind
  output logic         m_axis_tlast_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SLEEPERS);

  result_t            res_ctrl;
  result_t            res_out;
  logic               out_free;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  stq_ctrl #(
    .MAX_SLEEPERS(MAX_SLEEPERS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .op_i       (s_axis_tuser_i),
    .id_i       (s_axis_tdata_i[7:0]),
    .dur_i      (s_axis_tdata_i[39:8]),
    .out_free_i (out_free),
    .res_o      (res_ctrl),
    .we_o       (ram_we),
    .waddr_o    (ram_waddr),
    .wdata_o    (ram_wdata),
    .re_o       (ram_re),
    .raddr_o    (ram_raddr),
    .rdata_i    (ram_rdata)
  );

  stq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_SLEEPERS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stq_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res_ctrl),
    .free_o  (out_free),
    .res_o   (res_out),
    .ready_i (m_axis_tready_i)
  );

  assign m_axis_tvalid_o = res_out.valid;
  assign m_axis_tdata_o  = {2'b00, res_out.now, res_out.wake, res_out.id};
  assign m_axis_tuser_o  = res_out.kind;
  assign m_axis_tlast_o  = res_out.last;

endmodule

// ===== verif/stq_wake_checker.sv =====
// Op codes shared with the testbench top, and the checker of the sorted timer queue.
`timescale 1ns / 100ps

package stq_tb_pkg;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_SLEEP = 1'b1
  } op_e;

endpackage

module stq_wake_checker
  import stq_pkg::*;
  import stq_tb_pkg::*;
#(
  parameter int unsigned SLEEPERS = MAX_SLEEPERS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [39:0]  s_axis_tdata_i,   // thread_id[7:0], sleep_ticks[39:8]
  input  logic         s_axis_tuser_i,   // op
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [135:0] m_axis_tdata_i,   // woken_id[7:0], wake_time[70:8], now_ticks[133:71]
  input  logic [1:0]   m_axis_tuser_i,   // kind
  input  logic         m_axis_tlast_i,
  output int unsigned  mismatch_count_o,
  output int unsigned  results_waiting_o
);

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] wake;
    logic [TIME_W-1:0] now;
    logic              last;
  } answer_t;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic [TIME_W-1:0] tick_now;
  logic [TIME_W-1:0] sleeper_due [SLEEPERS];
  logic [ID_W-1:0]   sleeper_tid [SLEEPERS];
  int unsigned       sleeper_cnt;
  answer_t           queue_answers_q[$];
  int unsigned       mismatches = 0;

  function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                      logic [TIME_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Wake time saturates at the top of the 63-bit range; a full table leaves the state alone.
  function automatic void enqueue_sleeper(logic [ID_W-1:0] tid, logic [DUR_W-1:0] dur);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] due;
    int unsigned       pos;
    int unsigned       k;
    answer_t           ans;
    sum = {1'b0, tick_now} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur};
    due = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    ans.id   = tid;
    ans.wake = due;
    ans.now  = tick_now;
    ans.last = 1'b1;
    if (sleeper_cnt >= SLEEPERS) begin
      ans.kind = KIND_REJECTED;
    end else begin
      ans.kind = KIND_ACCEPTED;
      pos = 0;
      while (pos < sleeper_cnt && sleeper_due[pos] <= due) pos++;
      for (k = sleeper_cnt; k > pos; k--) begin
        sleeper_due[k] = sleeper_due[k-1];
        sleeper_tid[k] = sleeper_tid[k-1];
      end
      sleeper_due[pos] = due;
      sleeper_tid[pos] = tid;
      sleeper_cnt++;
    end
    queue_answers_q.push_back(ans);
  endfunction

  function automatic void release_due_sleepers();
    int unsigned n;
    int unsigned k;
    answer_t     ans;
    tick_now = tick_now + 1'b1;
    n = 0;
    while (n < sleeper_cnt && n < MAX_RESULTS && sleeper_due[n] <= tick_now) n++;
    for (k = 0; k < n; k++) begin
      ans.kind = KIND_WOKEN;
      ans.id   = sleeper_tid[k];
      ans.wake = sleeper_due[k];
      ans.now  = tick_now;
      ans.last = (k == n - 1);
      queue_answers_q.push_back(ans);
    end
    for (k = 0; k + n < sleeper_cnt; k++) begin
      sleeper_due[k] = sleeper_due[k+n];
      sleeper_tid[k] = sleeper_tid[k+n];
    end
    sleeper_cnt -= n;
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    if (!rst_ni) begin
      tick_now    = '0;
      sleeper_cnt = 0;
      queue_answers_q.delete();
    end else begin
      // Results of a beat taken at this edge cannot leave at the same edge, so compare first.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (queue_answers_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got kind %0d id %0h last %0b",
                   $time, m_axis_tuser_i, m_axis_tdata_i[ID_W-1:0], m_axis_tlast_i);
          mismatches++;
        end else begin
          want = queue_answers_q.pop_front();
          check_field("kind", want.kind, m_axis_tuser_i);
          check_field("woken_id", want.id, m_axis_tdata_i[ID_W-1:0]);
          check_field("wake_time", want.wake, m_axis_tdata_i[ID_W +: TIME_W]);
          check_field("now_ticks", want.now, m_axis_tdata_i[ID_W+TIME_W +: TIME_W]);
          check_field("last", want.last, m_axis_tlast_i);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (op_e'(s_axis_tuser_i) == OP_SLEEP) begin
          enqueue_sleeper(s_axis_tdata_i[ID_W-1:0], s_axis_tdata_i[ID_W +: DUR_W]);
        end else begin
          release_due_sleepers();
        end
      end
    end
    mismatch_count_o  <= mismatches;
    results_waiting_o <= queue_answers_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top of the sorted timer queue: clock, reset, beat traffic and the verdict.
`timescale 1ns / 100ps

module tb_top;
  import stq_pkg::*;
  import stq_tb_pkg::*;

  localparam int unsigned SLEEPERS       = MAX_SLEEPERS_DEF;
  localparam int unsigned RANDOM_ITEMS   = 280;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [39:0]  s_data = '0;
  logic         s_user = OP_TICK;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [135:0] m_data;
  logic [1:0]   m_user;
  logic         m_last;

  logic         idle_on = 1'b1;
  int unsigned  stall_left = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  mismatch_count;
  int unsigned  results_waiting;

  sleep_wakeup_timer_queue #(
    .MAX_SLEEPERS(SLEEPERS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  stq_wake_checker #(
    .SLEEPERS(SLEEPERS)
  ) checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_valid),
    .s_axis_tready_i  (s_ready),
    .s_axis_tdata_i   (s_data),
    .s_axis_tuser_i   (s_user),
    .m_axis_tvalid_i  (m_valid),
    .m_axis_tready_i  (m_ready),
    .m_axis_tdata_i   (m_data),
    .m_axis_tuser_i   (m_user),
    .m_axis_tlast_i   (m_last),
    .mismatch_count_o (mismatch_count),
    .results_waiting_o(results_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: ready drops in bursts of random length while idling is on.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_ready    <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** sleep_wakeup_timer_queue: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(op_e op, logic [ID_W-1:0] tid, logic [DUR_W-1:0] dur);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {dur, tid};
    do @(posedge clk); while (!s_ready);
    @(negedge clk);
  endtask

  // Ticks carry random data, which the block must ignore.
  task automatic send_tick();
    send_beat(OP_TICK, ID_W'($urandom), $urandom);
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 3);
    if (r < 90) return $urandom_range(4, 24);
    if (r < 98) return $urandom_range(25, 60);
    return $urandom;
  endfunction

  initial begin
    int unsigned i;
    logic        filling;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero-tick sleep wakes at the next tick; a second tick finds nothing due.
    send_beat(OP_SLEEP, 8'h00, 32'd0);
    send_tick();
    send_tick();
    // Extreme id and duration; this entry stays parked for the whole run.
    send_beat(OP_SLEEP, 8'hFF, 32'hFFFF_FFFF);
    // Fill the table with interleaved equal wake times to check arrival order among ties.
    for (i = 0; i < SLEEPERS - 1; i++) begin
      send_beat(OP_SLEEP, ID_W'(8'h10 + i), DUR_W'(i % 4));
    end
    send_beat(OP_SLEEP, 8'hA5, 32'd7);
    repeat (3) send_tick();
    send_beat(OP_SLEEP, 8'h5A, 32'd1);

    // Random part: groups of twelve items either mostly fill the table or mostly drain it, chosen at random.
    filling = 1'b1;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = (i < RANDOM_ITEMS - 50) && ((i / 35) % 3 != 2);
      if (i % 12 == 0) filling = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < (filling ? 7 : 3)) begin
        send_beat(OP_SLEEP, ID_W'($urandom), pick_duration());
      end else begin
        send_tick();
      end
    end
    s_valid <= 1'b0;

    while (results_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("** sleep_wakeup_timer_queue: PASSED **");
    end else begin
      $display("** sleep_wakeup_timer_queue: FAILED **");
    end
    $finish;
  end

endmodule
